@@ hdl/lxfc_pkg.sv @@
// Package of the length/XOR frame checker: codes, constants and shared types.
`default_nettype none
package lxfc_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CountW   = 9;

  localparam logic [7:0]        StartByteReset = 8'hFF;
  localparam logic [7:0]        MaxLenReset    = 8'd27;
  localparam logic [7:0]        TypeReadings   = 8'h31;
  localparam logic [7:0]        TypeSettings   = 8'h01;
  localparam logic [CountW-1:0] CountMax       = '1;
  // Frame overhead: start, two header bytes, length byte and checksum.
  localparam logic [CountW-1:0] FrameOverhead  = CountW'(5);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_BYTE = 2'd0,
    CFG_MAX_LEN    = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_START    = 3'd1,
    ST_LEN_MISMATCH = 3'd2,
    ST_TOO_LONG     = 3'd3,
    ST_ZERO_LEN     = 3'd4,
    ST_BAD_CHECKSUM = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    CL_UNKNOWN      = 3'd0,
    CL_READINGS_OK  = 3'd1,
    CL_READINGS_BAD = 3'd2,
    CL_SETTINGS_OK  = 3'd3,
    CL_SETTINGS_BAD = 3'd4
  } class_e;

  // Everything the evaluator needs about one completed frame.
  typedef struct packed {
    logic              start_ok;
    logic [CountW-1:0] byte_count;
    logic [7:0]        xor_sum;
    logic [7:0]        length_byte;
    logic [7:0]        type_byte;
    logic [7:0]        chan_byte;
  } frame_sum_t;

  typedef struct packed {
    status_e    status;
    class_e     payload_class;
    logic [7:0] data_length;
  } result_t;

endpackage
`default_nettype wire

@@ hdl/lxfc_if.sv @@
// Channel interfaces of the frame checker: byte input, result output, register write.
`default_nettype none
interface lxfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface lxfc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [2:0] payload_class;
  logic [7:0] data_length;
  modport source (output valid, output status, output payload_class,
                  output data_length, input ready);
  modport sink   (input valid, input status, input payload_class,
                  input data_length, output ready);
endinterface

interface lxfc_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/lxfc_track.sv @@
// Per-frame state tracker: byte count, running XOR, captured bytes and frame summary register.
`default_nettype none
module lxfc_track import lxfc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_byte_i,
  input  wire logic [7:0] start_byte_i,
  input  wire logic       take_i,
  output logic            sum_valid_o,
  output frame_sum_t      sum_o,
  output logic [CountW-1:0] count_o
);

  frame_sum_t cur_q, cur_d;
  frame_sum_t upd;
  frame_sum_t sum_q;
  logic       sum_valid_q, sum_valid_d;

  // State as it stands once the current byte is folded in.
  always_comb begin
    upd = cur_q;
    if (cur_q.byte_count == '0) begin
      upd.start_ok = (data_byte_i == start_byte_i);
    end else begin
      upd.xor_sum = cur_q.xor_sum ^ data_byte_i;
    end
    if (cur_q.byte_count == CountW'(3)) upd.length_byte = data_byte_i;
    if (cur_q.byte_count == CountW'(4)) upd.type_byte   = data_byte_i;
    if (cur_q.byte_count == CountW'(6)) upd.chan_byte   = data_byte_i;
    if (cur_q.byte_count != CountMax) upd.byte_count = cur_q.byte_count + CountW'(1);
  end

  always_comb begin
    cur_d = cur_q;
    if (accept_i) begin
      cur_d = last_byte_i ? '0 : upd;
    end
    sum_valid_d = sum_valid_q;
    if (take_i) sum_valid_d = 1'b0;
    if (accept_i && last_byte_i) sum_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      sum_valid_q <= 1'b0;
    end else begin
      cur_q       <= cur_d;
      sum_valid_q <= sum_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && last_byte_i) sum_q <= upd;
  end

  assign sum_valid_o = sum_valid_q;
  assign sum_o       = sum_q;
  assign count_o     = cur_q.byte_count;

endmodule
`default_nettype wire

@@ hdl/lxfc_judge.sv @@
// Frame evaluator: status checks in priority order and payload classification.
`default_nettype none
module lxfc_judge import lxfc_pkg::*; (
  input  wire frame_sum_t sum_i,
  input  wire logic [7:0] max_len_i,
  output result_t         result_o
);

  logic       len_match;
  logic [9:0] settings_len;
  class_e     cls;

  assign len_match = (sum_i.byte_count >= FrameOverhead) &&
                     ((sum_i.byte_count - FrameOverhead) == {1'b0, sum_i.length_byte});
  // Expected settings length, three plus two bytes per channel, without wrap.
  assign settings_len = 10'd3 + {1'b0, sum_i.chan_byte, 1'b0};

  always_comb begin
    cls = CL_UNKNOWN;
    if (sum_i.type_byte == TypeReadings) begin
      cls = (sum_i.length_byte >= 8'd6 && sum_i.length_byte[0]) ?
            CL_READINGS_OK : CL_READINGS_BAD;
    end else if (sum_i.type_byte == TypeSettings) begin
      if (sum_i.length_byte < 8'd3) begin
        cls = CL_SETTINGS_BAD;
      end else begin
        cls = ({2'b00, sum_i.length_byte} == settings_len) ?
              CL_SETTINGS_OK : CL_SETTINGS_BAD;
      end
    end
  end

  always_comb begin
    result_o.payload_class = CL_UNKNOWN;
    if (!sum_i.start_ok) begin
      result_o.status = ST_BAD_START;
    end else if (!len_match) begin
      result_o.status = ST_LEN_MISMATCH;
    end else if (sum_i.length_byte > max_len_i) begin
      result_o.status = ST_TOO_LONG;
    end else if (sum_i.length_byte == 8'd0) begin
      result_o.status = ST_ZERO_LEN;
    end else if (sum_i.xor_sum != 8'd0) begin
      result_o.status = ST_BAD_CHECKSUM;
    end else begin
      result_o.status        = ST_OK;
      result_o.payload_class = cls;
    end
    result_o.data_length = (sum_i.byte_count >= CountW'(4)) ? sum_i.length_byte : 8'd0;
  end

endmodule
`default_nettype wire

@@ hdl/length_xor_frame_checker.sv @@
// Top level of the length-prefixed frame checker with XOR checksum.
//
//   Channel  Dir  Handshake     Payload
//   in_i     in   valid/ready   data_byte[7:0], last_byte
//   out_o    out  valid/ready   status[2:0], payload_class[2:0], data_length[7:0]
//   cfg_i    in   valid/ready   index[1:0], data[7:0] (0 start byte, 1 max length)
//
// One byte is taken per cycle while in_i.ready is high. A byte marked last is
// folded into the frame state and its summary registered; the evaluator turns
// that summary into a result that is loaded into the output register once
// that register is empty or being drained. Reset clears the frame state, both
// pipeline valids and loads the register defaults. A stalled output only holds
// back the input once the summary register is also full.
`default_nettype none
module length_xor_frame_checker import lxfc_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  lxfc_in_if.sink     in_i,
  lxfc_out_if.source  out_o,
  lxfc_cfg_if.sink    cfg_i
);

  logic [7:0] start_byte_q, start_byte_d;
  logic [7:0] max_len_q, max_len_d;

  logic              in_accept;
  logic              sum_valid;
  frame_sum_t        sum;
  logic [CountW-1:0] count;
  logic              out_load;
  result_t           res;
  result_t           out_q;
  logic              out_valid_q, out_valid_d;

  // Register writes are always taken; unknown indexes are dropped.
  assign cfg_i.ready = 1'b1;

  always_comb begin
    start_byte_d = start_byte_q;
    max_len_d    = max_len_q;
    if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_START_BYTE: start_byte_d = cfg_i.data;
        CFG_MAX_LEN:    max_len_d    = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= StartByteReset;
      max_len_q    <= MaxLenReset;
    end else begin
      start_byte_q <= start_byte_d;
      max_len_q    <= max_len_d;
    end
  end

  // The summary moves on when the output register is empty or being drained.
  assign out_load    = sum_valid && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !sum_valid || out_load;
  assign in_accept   = in_i.valid && in_i.ready;

  lxfc_track u_track (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_accept),
    .data_byte_i  (in_i.data_byte),
    .last_byte_i  (in_i.last_byte),
    .start_byte_i (start_byte_q),
    .take_i       (out_load),
    .sum_valid_o  (sum_valid),
    .sum_o        (sum),
    .count_o      (count)
  );

  lxfc_judge u_judge (
    .sum_i     (sum),
    .max_len_i (max_len_q),
    .result_o  (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_o.ready) out_valid_d = 1'b0;
    if (out_load)    out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= res;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_q.status;
  assign out_o.payload_class = out_q.payload_class;
  assign out_o.data_length   = out_q.data_length;

  // A final byte always restarts the count for the next frame.
  a_count_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_i.last_byte |=> count == '0)
    else $error("byte count not cleared after final byte");

  // A new result only appears after a summary was waiting for it.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(sum_valid))
    else $error("result raised without a frame summary");

  // Input is only held off while a summary is stuck behind a full output.
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> sum_valid && out_valid_q && !out_o.ready)
    else $error("input stalled without back pressure");

  // Failed frames never carry a payload class.
  a_class_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.status != ST_OK) |-> out_o.payload_class == CL_UNKNOWN)
    else $error("payload class given for a failed frame");

endmodule
`default_nettype wire
